// ===== hdl/phd_pkg.sv =====
// Shared types and constants for the PPP async HDLC deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package phd_pkg;

  // framing bytes of PPP async HDLC
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // hard upper bound on stored bytes per frame
  localparam logic [15:0] MAX_FRAME = 16'd4096;

  localparam int unsigned LEN_W = 13;

  // configuration register indexes
  localparam logic REG_CONVERT_MODE = 1'b0;
  localparam logic REG_MAX_LEN      = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_ESC_FLAG = 3'd2,
    ST_OVERRUN  = 3'd3,
    ST_SHORT    = 3'd4
  } status_t;

  // per-frame control state
  typedef struct packed {
    logic             escape_pending;
    logic [LEN_W-1:0] byte_count;
  } frame_state_t;

  // one result request, valid marks that the byte produced one
  typedef struct packed {
    logic             valid;
    logic             has_byte;
    logic [7:0]       data_byte;
    logic             frame_end;
    logic [LEN_W-1:0] frame_length;
    status_t          status;
  } result_t;

endpackage

// ===== hdl/phd_decode.sv =====
// Per-byte de-stuffing and framing decision for the deframer.
// Depends on phd_pkg; purely combinational.
`timescale 1ns / 1ps

module phd_decode import phd_pkg::*; (
  input  logic             convert_mode,
  input  logic [LEN_W-1:0] max_len,
  input  logic [7:0]       in_byte,
  input  frame_state_t     state,
  input  logic [7:0]       hold_oldest,
  output frame_state_t     state_next,
  output logic             shift,
  output logic [7:0]       shift_byte,
  output result_t          result
);

  logic [LEN_W-1:0] limit;
  logic [7:0]       data;
  logic             below_limit;

  // limit in force is the smaller of max_len and the hard bound
  always_comb begin
    if ({3'b000, max_len} < MAX_FRAME) begin
      limit = max_len;
    end else begin
      limit = MAX_FRAME[LEN_W-1:0];
    end
  end

  assign below_limit = state.byte_count < limit;
  assign data = (convert_mode && state.escape_pending) ? (in_byte ^ ESC_XOR) : in_byte;
  assign shift_byte = data;

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    result     = '0;
    result.status = ST_DATA;
    if (in_byte == FLAG_BYTE) begin
      // flag closes the frame
      if (state.escape_pending) begin
        state_next      = '0;
        result.valid    = 1'b1;
        result.frame_end = 1'b1;
        result.status   = ST_ESC_FLAG;
      end else if (convert_mode) begin
        if (state.byte_count != '0) begin
          state_next       = '0;
          result.valid     = 1'b1;
          result.frame_end = 1'b1;
          if (state.byte_count == LEN_W'(1)) begin
            result.status = ST_SHORT;
          end else begin
            result.status       = ST_GOOD;
            result.frame_length = state.byte_count - LEN_W'(2);
          end
        end
      end else begin
        // raw mode passes the flag when there is room
        state_next       = '0;
        result.valid     = 1'b1;
        result.frame_end = 1'b1;
        result.status    = ST_GOOD;
        if (below_limit) begin
          result.has_byte     = 1'b1;
          result.data_byte    = FLAG_BYTE;
          result.frame_length = state.byte_count + LEN_W'(1);
        end else begin
          result.frame_length = state.byte_count;
        end
      end
    end else if (in_byte == ESC_BYTE && convert_mode) begin
      state_next.escape_pending = 1'b1;
    end else begin
      state_next.escape_pending = 1'b0;
      if (!below_limit) begin
        // overrun discards the frame
        state_next       = '0;
        result.valid     = 1'b1;
        result.frame_end = 1'b1;
        result.status    = ST_OVERRUN;
      end else begin
        shift = 1'b1;
        state_next.byte_count = state.byte_count + LEN_W'(1);
        if (!convert_mode) begin
          result.valid     = 1'b1;
          result.has_byte  = 1'b1;
          result.data_byte = data;
        end else if (state.byte_count >= LEN_W'(2)) begin
          // release the byte two places back, the fcs stays held
          result.valid     = 1'b1;
          result.has_byte  = 1'b1;
          result.data_byte = hold_oldest;
        end
      end
    end
  end

endmodule

// ===== hdl/phd_outreg.sv =====
// Output result register of the deframer, holds one request under stall.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_outreg import phd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  result_t          result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             has_byte,
  output logic [7:0]       data_byte,
  output logic             frame_end,
  output logic [LEN_W-1:0] frame_length,
  output logic [2:0]       status
);

  result_t held;

  // register can take a new request when empty or being drained
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load && result.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (free && load && result.valid) begin
      held <= result;
    end
  end

  assign has_byte     = held.has_byte;
  assign data_byte    = held.data_byte;
  assign frame_end    = held.frame_end;
  assign frame_length = held.frame_length;
  assign status       = held.status;

endmodule

// ===== hdl/ppp_async_hdlc_deframer_top.sv =====
// Top level of the PPP async HDLC deframer: input register, frame state,
// config registers. Depends on phd_pkg, phd_decode and phd_outreg.
`timescale 1ns / 1ps

// Takes one received serial byte per request and yields at most one result
// per byte. Sustained rate is one byte per clock while the output is not
// stalled: a byte is registered in the input register, and the frame state
// and two-byte FCS hold line update as it moves into the output register,
// which drives its result on the outputs. Bytes that produce nothing
// (escapes, bytes still held for the FCS, empty frames) drain without a
// result. Configuration writes must happen only while no byte is in
// flight.
module ppp_async_hdlc_deframer_top import phd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             has_byte,
  output logic [7:0]       data_byte,
  output logic             frame_end,
  output logic [LEN_W-1:0] frame_length,
  output logic [2:0]       status
);

  logic             convert_mode;
  logic [LEN_W-1:0] max_len;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             advance;
  logic             out_free;
  frame_state_t     state;
  frame_state_t     state_next;
  logic [7:0]       hold_bytes [2];
  logic             shift;
  logic [7:0]       shift_byte;
  result_t          result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      convert_mode <= 1'b1;
      max_len      <= LEN_W'(4096);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CONVERT_MODE: convert_mode <= cfg_data[0];
        REG_MAX_LEN:      max_len      <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input register
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  phd_decode u_decode (
    .convert_mode (convert_mode),
    .max_len      (max_len),
    .in_byte      (s1_byte),
    .state        (state),
    .hold_oldest  (hold_bytes[0]),
    .state_next   (state_next),
    .shift        (shift),
    .shift_byte   (shift_byte),
    .result       (result)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // fcs hold line
  always_ff @(posedge clk) begin
    if (advance && shift) begin
      hold_bytes[0] <= hold_bytes[1];
      hold_bytes[1] <= shift_byte;
    end
  end

  phd_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .result       (result),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_byte     (has_byte),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .frame_length (frame_length),
    .status       (status)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ppp_async_hdlc_deframer_top: queue-fed byte driver,
// result monitor and a byte-level de-stuffing predictor. Depends on phd_pkg.

module tb_top;
  import phd_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int HANG_LIMIT   = 2000;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic             has_byte;
    logic [7:0]       data_byte;
    logic             frame_end;
    logic [LEN_W-1:0] frame_length;
    status_t          status;
  } deframe_res_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_kind_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_CONVERT_MODE;
  logic [LEN_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_byte   = 8'h00;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             has_byte;
  logic [7:0]       data_byte;
  logic             frame_end;
  logic [LEN_W-1:0] frame_length;
  logic [2:0]       status;

  ppp_async_hdlc_deframer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_byte     (has_byte),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .frame_length (frame_length),
    .status       (status)
  );

  always #2 clk = ~clk;

  // predictor copy of registers and frame state
  logic             mdl_convert = 1'b1;
  logic [LEN_W-1:0] mdl_max_len = LEN_W'(4096);
  logic             mdl_escape  = 1'b0;
  logic [LEN_W-1:0] mdl_count   = '0;
  logic [7:0]       mdl_hold [2] = '{8'h00, 8'h00};

  logic [7:0]   line_bytes_q [$];
  deframe_res_t exp_results_q [$];

  int bytes_taken  = 0;
  int results_seen = 0;
  int bad_results  = 0;
  int cfg_writes   = 0;
  int status_seen [5] = '{default: 0};

  function automatic deframe_res_t make_res(logic h, logic [7:0] d, logic e,
                                            logic [LEN_W-1:0] n, status_t s);
    deframe_res_t r;
    r.has_byte     = h;
    r.data_byte    = d;
    r.frame_end    = e;
    r.frame_length = n;
    r.status       = s;
    return r;
  endfunction

  function automatic void close_frame();
    mdl_count  = '0;
    mdl_escape = 1'b0;
  endfunction

  // de-stuff one line byte; returns 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output deframe_res_t r);
    logic [7:0]       c;
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] n;
    logic [7:0]       oldest;
    bit               rel;
    c   = b;
    lim = (32'(mdl_max_len) < 32'(MAX_FRAME)) ? mdl_max_len : LEN_W'(MAX_FRAME);
    r   = make_res(1'b0, 8'h00, 1'b0, '0, ST_DATA);
    n   = mdl_count;

    if (b == FLAG_BYTE) begin
      // escaped flag aborts in either mode
      if (mdl_escape) begin
        close_frame();
        r = make_res(1'b0, 8'h00, 1'b1, '0, ST_ESC_FLAG);
        return 1'b1;
      end
      if (mdl_convert) begin
        if (n == 0) return 1'b0;
        close_frame();
        if (n < 2) r = make_res(1'b0, 8'h00, 1'b1, '0, ST_SHORT);
        else       r = make_res(1'b0, 8'h00, 1'b1, n - 2'd2, ST_GOOD);
        return 1'b1;
      end
      // raw mode delivers the flag unless the frame is full
      close_frame();
      if (n < lim) r = make_res(1'b1, FLAG_BYTE, 1'b1, n + 1'b1, ST_GOOD);
      else         r = make_res(1'b0, 8'h00, 1'b1, n, ST_GOOD);
      return 1'b1;
    end

    if (b == ESC_BYTE && mdl_convert) begin
      mdl_escape = 1'b1;
      return 1'b0;
    end
    if (mdl_convert && mdl_escape) c = b ^ ESC_XOR;
    mdl_escape = 1'b0;

    if (mdl_count >= lim) begin
      close_frame();
      r = make_res(1'b0, 8'h00, 1'b1, '0, ST_OVERRUN);
      return 1'b1;
    end

    // two-byte hold line drops the fcs in convert mode
    oldest      = mdl_hold[0];
    rel         = (mdl_count >= 2);
    mdl_hold[0] = mdl_hold[1];
    mdl_hold[1] = c;
    mdl_count   = mdl_count + 1'b1;
    if (!mdl_convert) begin
      r = make_res(1'b1, c, 1'b0, '0, ST_DATA);
      return 1'b1;
    end
    if (rel) begin
      r = make_res(1'b1, oldest, 1'b0, '0, ST_DATA);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // byte driver: bursts of requests with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_bytes
    deframe_res_t r;
    bit           take;
    take = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        bytes_taken++;
        if (deframe_byte(in_byte, r)) exp_results_q.push_back(r);
      end
      if (take || !in_valid) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_bytes_q.size() > 0) begin
          in_byte  <= line_bytes_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall pattern, switching among randomly chosen styles
  stall_kind_t stall_kind = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_tick++;
    case (stall_kind)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default:        out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    deframe_res_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (status <= 3'd4) status_seen[status]++;
      if (exp_results_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_SHOWN)
          $display("%0t: unexpected result has=%0b data=%02h end=%0b len=%0d st=%0d",
                   $time, has_byte, data_byte, frame_end, frame_length, status);
      end else begin
        e = exp_results_q.pop_front();
        if (has_byte !== e.has_byte || data_byte !== e.data_byte ||
            frame_end !== e.frame_end || frame_length !== e.frame_length ||
            status !== 3'(e.status)) begin
          bad_results++;
          if (bad_results <= MAX_SHOWN) begin
            $display("%0t: mismatch exp has=%0b data=%02h end=%0b len=%0d st=%0d",
                     $time, e.has_byte, e.data_byte, e.frame_end, e.frame_length,
                     3'(e.status));
            $display("    got has=%0b data=%02h end=%0b len=%0d st=%0d",
                     has_byte, data_byte, frame_end, frame_length, status);
          end
        end
      end
    end
  end

  // watchdog on cycles where no request moves
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", HANG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [LEN_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_CONVERT_MODE) mdl_convert = val[0];
    else                         mdl_max_len = val;
    cfg_writes++;
  endtask

  // wait until all bytes are in, all results out, and the pipe is empty
  task automatic settle();
    do @(negedge clk);
    while (line_bytes_q.size() != 0 || in_valid || exp_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // stuff a payload byte; sometimes escape an ordinary byte too
  function automatic void push_stuffed(logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        ((b ^ ESC_XOR) != FLAG_BYTE && $urandom_range(0, 15) == 0)) begin
      line_bytes_q.push_back(ESC_BYTE);
      line_bytes_q.push_back(b ^ ESC_XOR);
    end else begin
      line_bytes_q.push_back(b);
    end
  endfunction

  function automatic void push_frame(int n);
    repeat (n) push_stuffed(rand_payload());
    line_bytes_q.push_back(FLAG_BYTE);
  endfunction

  task automatic random_config();
    logic [LEN_W-1:0] len;
    logic             conv;
    conv = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0:       len = LEN_W'(1);
      1:       len = LEN_W'(2);
      2:       len = LEN_W'(3);
      3:       len = LEN_W'($urandom_range(4, 12));
      4:       len = LEN_W'($urandom_range(1, 64));
      5:       len = LEN_W'(4095);
      6:       len = LEN_W'(4096);
      7:       len = LEN_W'($urandom_range(1, 4096));
      default: len = LEN_W'($urandom_range(6, 40));
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(REG_CONVERT_MODE, LEN_W'(conv));
      write_reg(REG_MAX_LEN, len);
    end else begin
      write_reg(REG_MAX_LEN, len);
      write_reg(REG_CONVERT_MODE, LEN_W'(conv));
    end
  endtask

  // mostly well formed frames, plus noise, aborts and frames near the limit
  task automatic random_phase(int target);
    int start;
    int lim;
    start = line_bytes_q.size();
    lim   = (32'(mdl_max_len) < 32'(MAX_FRAME)) ? int'(mdl_max_len) : int'(MAX_FRAME);
    while (line_bytes_q.size() - start < target) begin
      case ($urandom_range(0, 9))
        7: repeat ($urandom_range(1, 6)) line_bytes_q.push_back(8'($urandom_range(0, 255)));
        8: begin
          repeat ($urandom_range(0, 4)) push_stuffed(rand_payload());
          line_bytes_q.push_back(ESC_BYTE);
          line_bytes_q.push_back(FLAG_BYTE);
        end
        9: begin
          if (lim <= 40) push_frame($urandom_range(lim - 1, lim + 3));
          else           push_frame($urandom_range(0, 48));
        end
        default: push_frame(($urandom_range(0, 7) == 0) ? $urandom_range(12, 48)
                                                         : $urandom_range(0, 10));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [7:0] b;
    int         errors;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // convert mode at reset values: empty, short, escapes, good, escaped flag
    line_bytes_q = {line_bytes_q, 8'h7E, 8'h00, 8'h7E, 8'hFF, 8'h7D, 8'h5E, 8'h7D,
                    8'h7D, 8'h5D, 8'h11, 8'h22, 8'h7E, 8'h7D, 8'h7E};
    settle();

    // raw mode: escape passes, flag delivered
    write_reg(REG_CONVERT_MODE, LEN_W'(0));
    line_bytes_q = {line_bytes_q, 8'h41, 8'h7D, 8'h7E, 8'h7E};
    settle();

    // raw mode at the smallest limit: flag when full, overrun
    write_reg(REG_MAX_LEN, LEN_W'(1));
    line_bytes_q = {line_bytes_q, 8'h10, 8'h7E, 8'h10, 8'h20, 8'h7E};
    settle();

    // convert mode at the smallest limit, ending on a pending escape
    write_reg(REG_CONVERT_MODE, LEN_W'(1));
    line_bytes_q = {line_bytes_q, 8'h33, 8'h44, 8'h55, 8'h7E, 8'h7D};
    settle();

    // escape left pending across the switch to raw, then a flag
    write_reg(REG_CONVERT_MODE, LEN_W'(0));
    line_bytes_q.push_back(FLAG_BYTE);
    settle();

    // raw frame filled to a mid-size limit and closed by a flag when full
    write_reg(REG_MAX_LEN, LEN_W'(150));
    repeat (150) begin
      b = 8'($urandom_range(0, 255));
      line_bytes_q.push_back((b == FLAG_BYTE) ? 8'h00 : b);
    end
    line_bytes_q.push_back(FLAG_BYTE);
    settle();

    // convert frame at the same limit driven into overrun
    write_reg(REG_CONVERT_MODE, LEN_W'(1));
    repeat (151) begin
      b = 8'($urandom_range(0, 255));
      line_bytes_q.push_back((b == FLAG_BYTE || b == ESC_BYTE) ? 8'h00 : b);
    end
    line_bytes_q.push_back(FLAG_BYTE);
    settle();

    // random phases, each under its own setting; frames may span a switch
    repeat (6) begin
      random_config();
      random_phase(125);
      settle();
    end

    repeat (20) @(negedge clk);
    errors = bad_results + exp_results_q.size();
    if (exp_results_q.size() != 0)
      $display("%0d expected results never arrived", exp_results_q.size());
    $display("run covered %0d line bytes, %0d results, %0d register writes, %0d bad",
             bytes_taken, results_seen, cfg_writes, bad_results);
    $display("frames closed: good %0d, escaped flag %0d, overrun %0d, short %0d",
             status_seen[ST_GOOD], status_seen[ST_ESC_FLAG], status_seen[ST_OVERRUN],
             status_seen[ST_SHORT]);
    if (errors == 0) $display("RESULT: OK");
    else             $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== ppp_async_hdlc_deframer_top.f =====
hdl/phd_pkg.sv
hdl/phd_decode.sv
hdl/phd_outreg.sv
hdl/ppp_async_hdlc_deframer_top.sv
dv/tb_top.sv
